[rtl/tt_pkg.sv]
// ============================================================================
// Timed tag table package
// Shared widths, command codes and the control word that moves down the
// cell chain together with each request.
// ============================================================================
`default_nettype none

package tt_pkg;

  // Widths of the request and entry fields.
  localparam int KEY_W = 16;
  localparam int DUR_W = 16;
  localparam int CMD_W = 2;

  // Default configuration of the table.
  localparam int DEF_ENTRIES  = 32;
  localparam int DEF_KEY_BITS = 16;

  typedef logic [CMD_W-1:0] cmd_t;

  localparam cmd_t CMD_TAG   = 2'd0;
  localparam cmd_t CMD_QUERY = 2'd1;
  localparam cmd_t CMD_TICK  = 2'd2;

  // Control word of a request as it passes from cell to cell.
  typedef struct packed {
    logic valid;
    cmd_t cmd;
    logic hit;         // the key was found in an earlier cell
    logic free_found;  // a free entry has been seen in an earlier cell
    logic answer;      // query answer gathered so far
  } tok_ctl_t;

endpackage : tt_pkg

`default_nettype wire

[rtl/tt_cell.sv]
// ============================================================================
// Timed tag table cell
// Holds one table entry, applies the passing request to it and hands the
// request on to the next cell through its output registers.
// ============================================================================
`default_nettype none

module tt_cell #(
  parameter int CELL_IDX = 0,
  parameter int KW       = tt_pkg::DEF_KEY_BITS,
  parameter int IDX_W    = 5
) (
  input  wire                            clk,
  input  wire                            rst_n,
  // Request coming from the previous cell.
  input  tt_pkg::tok_ctl_t               ctl_in,
  input  wire  [KW-1:0]                  key_in,
  input  wire  signed [tt_pkg::DUR_W-1:0] dur_in,
  input  wire  [IDX_W-1:0]               idx_in,
  // Request handed to the next cell.
  output tt_pkg::tok_ctl_t               ctl_out_r,
  output logic [KW-1:0]                  key_out_r,
  output logic signed [tt_pkg::DUR_W-1:0] dur_out_r,
  output logic [IDX_W-1:0]               idx_out_r,
  // Addressed write used to place a new key.
  input  wire                            wr_en,
  input  wire  [IDX_W-1:0]               wr_idx,
  input  wire  [KW-1:0]                  wr_key,
  input  wire  signed [tt_pkg::DUR_W-1:0] wr_dur
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

  logic [KW-1:0]                    key_r, key_nxt;
  logic signed [tt_pkg::DUR_W-1:0]  time_r, time_nxt;
  tt_pkg::tok_ctl_t                 ctl_nxt;
  logic [IDX_W-1:0]                 idx_nxt;
  logic                             match;
  logic signed [tt_pkg::DUR_W:0]    dec;

  assign match = ctl_in.valid && (key_r == key_in) && (key_in != '0);
  assign dec   = {time_r[tt_pkg::DUR_W-1], time_r} - 17'sd1;

  always_comb begin
    key_nxt  = key_r;
    time_nxt = time_r;
    ctl_nxt  = ctl_in;
    idx_nxt  = idx_in;
    if (ctl_in.valid) begin
      unique case (ctl_in.cmd)
        tt_pkg::CMD_TAG: begin
          if (match) begin
            ctl_nxt.hit = 1'b1;
            if (dur_in > time_r) begin
              time_nxt = dur_in;
            end
          end
          if (key_r == '0 && !ctl_in.free_found) begin
            ctl_nxt.free_found = 1'b1;
            idx_nxt            = MY_IDX;
          end
        end
        tt_pkg::CMD_QUERY: begin
          if (match && time_r > 16'sd0) begin
            ctl_nxt.answer = 1'b1;
          end
        end
        tt_pkg::CMD_TICK: begin
          if (key_r != '0) begin
            if (dec <= 17'sd0) begin
              key_nxt  = '0;
              time_nxt = '0;
            end else begin
              time_nxt = dec[tt_pkg::DUR_W-1:0];
            end
          end
        end
        default: begin
        end
      endcase
    end
    if (wr_en && wr_idx == MY_IDX) begin
      key_nxt  = wr_key;
      time_nxt = wr_dur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r           <= '0;
      time_r          <= '0;
      ctl_out_r.valid <= 1'b0;
    end else begin
      key_r           <= key_nxt;
      time_r          <= time_nxt;
      ctl_out_r.valid <= ctl_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    ctl_out_r.cmd        <= ctl_nxt.cmd;
    ctl_out_r.hit        <= ctl_nxt.hit;
    ctl_out_r.free_found <= ctl_nxt.free_found;
    ctl_out_r.answer     <= ctl_nxt.answer;
    key_out_r            <= key_in;
    dur_out_r            <= dur_in;
    idx_out_r            <= idx_nxt;
  end

endmodule : tt_cell

`default_nettype wire

[rtl/timed_tag_table.sv]
// ============================================================================
// Timed tag table
// Associative table of keys with remaining times, built as a chain of
// entry cells that each request walks through one cell per cycle.
// ============================================================================
//
//   Channel   Direction  Handshake          Payload
//   in_       request    in_valid/in_stall  in_command, in_key, in_duration
//   out_      result     out_valid/out_stall out_is_tagged
//
// A request is taken only while the table is idle, so a new request is not
// accepted before the last one is through. The accepting edge loads the
// request register, and from there the request passes through each cell of
// the chain in turn before it moves from the last cell into the finish stage.
// In the finish cycle a tag of a new key writes the lowest free entry, or a
// query answer is loaded into the output register. The input stall drops at
// the end of the finish cycle, and the next request can then be taken. A query
// answer is visible on the output from the edge that ends its finish cycle.
// Reset is synchronous and active low; it clears every entry to free.
// A stalled query answer waits in the finish stage until the output
// register can take it; no new request is taken until then.
// Only a query produces a result; tags, ticks and the unused command code
// produce none.
//
`default_nettype none

module timed_tag_table #(
  parameter int TABLE_ENTRIES = tt_pkg::DEF_ENTRIES,
  parameter int KEY_BITS      = tt_pkg::DEF_KEY_BITS
) (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             in_valid,
  output logic                            in_stall,
  input  wire  [tt_pkg::CMD_W-1:0]        in_command,
  input  wire  [tt_pkg::KEY_W-1:0]        in_key,
  input  wire  signed [tt_pkg::DUR_W-1:0] in_duration,
  output logic                            out_valid,
  input  wire                             out_stall,
  output logic                            out_is_tagged
);

  // Only the low KEY_BITS bits of the key take part, capped by the port.
  localparam int KW    = (KEY_BITS < tt_pkg::KEY_W) ? KEY_BITS : tt_pkg::KEY_W;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  // Chain nodes: node 0 is the registered request, node i+1 the output of
  // cell i.
  tt_pkg::tok_ctl_t                ctl_c [TABLE_ENTRIES+1];
  logic [KW-1:0]                   key_c [TABLE_ENTRIES+1];
  logic signed [tt_pkg::DUR_W-1:0] dur_c [TABLE_ENTRIES+1];
  logic [IDX_W-1:0]                idx_c [TABLE_ENTRIES+1];

  tt_pkg::tok_ctl_t                req_ctl_r, req_ctl_nxt;
  logic [KW-1:0]                   req_key_r;
  logic signed [tt_pkg::DUR_W-1:0] req_dur_r;

  tt_pkg::tok_ctl_t                fin_ctl_r;
  logic                            fin_valid_nxt;
  logic [KW-1:0]                   fin_key_r;
  logic signed [tt_pkg::DUR_W-1:0] fin_dur_r;
  logic [IDX_W-1:0]                fin_idx_r;

  logic busy_r, busy_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_tag_r;

  logic in_acc;
  logic out_load;
  logic fin_done;
  logic fin_query;

  logic                            wr_en;
  logic [TABLE_ENTRIES+1:0]        live_vec;

  // A request is taken only when nothing is in flight.
  assign in_stall = busy_r;
  assign in_acc   = in_valid && !busy_r;

  always_comb begin
    req_ctl_nxt            = '0;
    req_ctl_nxt.valid      = in_acc;
    req_ctl_nxt.cmd        = in_command;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_ctl_r.valid <= 1'b0;
    end else begin
      req_ctl_r.valid <= req_ctl_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    req_ctl_r.cmd        <= req_ctl_nxt.cmd;
    req_ctl_r.hit        <= req_ctl_nxt.hit;
    req_ctl_r.free_found <= req_ctl_nxt.free_found;
    req_ctl_r.answer     <= req_ctl_nxt.answer;
    req_key_r            <= in_key[KW-1:0];
    req_dur_r            <= in_duration;
  end

  assign ctl_c[0] = req_ctl_r;
  assign key_c[0] = req_key_r;
  assign dur_c[0] = req_dur_r;
  assign idx_c[0] = '0;

  // The row of entry cells. Each one holds a single key and its time.
  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    tt_cell #(
      .CELL_IDX (g),
      .KW       (KW),
      .IDX_W    (IDX_W)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl_in    (ctl_c[g]),
      .key_in    (key_c[g]),
      .dur_in    (dur_c[g]),
      .idx_in    (idx_c[g]),
      .ctl_out_r (ctl_c[g+1]),
      .key_out_r (key_c[g+1]),
      .dur_out_r (dur_c[g+1]),
      .idx_out_r (idx_c[g+1]),
      .wr_en     (wr_en),
      .wr_idx    (fin_idx_r),
      .wr_key    (fin_key_r),
      .wr_dur    (fin_dur_r)
    );
  end

  // The finish stage holds the request after it has left the last cell.
  // A query waits here while the output register is full and stalled.
  assign out_load  = !out_valid_r || !out_stall;
  assign fin_query = fin_ctl_r.cmd == tt_pkg::CMD_QUERY;
  assign fin_done  = fin_ctl_r.valid && (!fin_query || out_load);

  // A tag whose key was not found claims the lowest free entry. A full
  // table drops it, and a zero key is never written.
  assign wr_en = fin_done && (fin_ctl_r.cmd == tt_pkg::CMD_TAG) && !fin_ctl_r.hit
                 && fin_ctl_r.free_found && (fin_key_r != '0);

  always_comb begin
    if (ctl_c[TABLE_ENTRIES].valid) begin
      fin_valid_nxt = 1'b1;
    end else if (fin_done) begin
      fin_valid_nxt = 1'b0;
    end else begin
      fin_valid_nxt = fin_ctl_r.valid;
    end
  end

  always_comb begin
    if (in_acc) begin
      busy_nxt = 1'b1;
    end else if (fin_done) begin
      busy_nxt = 1'b0;
    end else begin
      busy_nxt = busy_r;
    end
  end

  always_comb begin
    if (fin_done && fin_query) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_ctl_r.valid <= 1'b0;
      busy_r          <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      fin_ctl_r.valid <= fin_valid_nxt;
      busy_r          <= busy_nxt;
      out_valid_r     <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_c[TABLE_ENTRIES].valid) begin
      fin_ctl_r.cmd        <= ctl_c[TABLE_ENTRIES].cmd;
      fin_ctl_r.hit        <= ctl_c[TABLE_ENTRIES].hit;
      fin_ctl_r.free_found <= ctl_c[TABLE_ENTRIES].free_found;
      fin_ctl_r.answer     <= ctl_c[TABLE_ENTRIES].answer;
      fin_key_r            <= key_c[TABLE_ENTRIES];
      fin_dur_r            <= dur_c[TABLE_ENTRIES];
      fin_idx_r            <= idx_c[TABLE_ENTRIES];
    end
    if (fin_done && fin_query) begin
      out_tag_r <= fin_ctl_r.answer;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_is_tagged = out_tag_r;

  // Where the single request in flight currently sits.
  always_comb begin
    for (int i = 0; i <= TABLE_ENTRIES; i++) begin
      live_vec[i] = ctl_c[i].valid;
    end
    live_vec[TABLE_ENTRIES+1] = fin_ctl_r.valid;
  end

  // At most one request is anywhere in the chain or the finish stage.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(live_vec))
    else $error("more than one request in flight");

  // Anything in flight means the input side is closed.
  a_busy_covers: assert property (@(posedge clk) disable iff (!rst_n)
    (live_vec != '0) |-> busy_r)
    else $error("request in flight while input is open");

  // The placing write only happens with the chain empty.
  a_write_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (live_vec[TABLE_ENTRIES:0] == '0))
    else $error("entry write while a request walks the chain");

  // A new answer only appears after a query finished.
  a_out_from_query: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(fin_done && fin_query))
    else $error("result without a finished query");

  // After acceptance the request enters the chain on the next cycle.
  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (req_ctl_r.valid && busy_r))
    else $error("accepted request did not enter the chain");

endmodule : timed_tag_table

`default_nettype wire
